FILE: src/srs_pkg.sv
// Shared types, codes and constants of the SPI switch register access sequencer.
package srs_pkg;

  // Sizes.
  localparam int MAX_BYTES  = 8;
  localparam int BUF_AW     = $clog2(MAX_BYTES);
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 5;
  localparam int INQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 4;

  // SPI opcodes and switch register addresses.
  localparam logic [7:0] SPI_OP_READ    = 8'h60;
  localparam logic [7:0] SPI_OP_WRITE   = 8'h61;
  localparam logic [7:0] SPI_REG_STATUS = 8'hFE;
  localparam logic [7:0] SPI_REG_PAGE   = 8'hFF;
  localparam logic [7:0] SPI_REG_DATA   = 8'hF0;
  localparam logic [7:0] SPI_DUMMY      = 8'h00;
  localparam int         RACK_BIT       = 5;
  localparam int         SPIF_BIT       = 7;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_RD_BUSY_LIM  = 2'd0;
  localparam logic [1:0] CFG_WR_BUSY_LIM  = 2'd1;
  localparam logic [1:0] CFG_ACK_TRIES    = 2'd2;
  localparam logic [CNT_W-1:0] RD_BUSY_RST = 5'd10;
  localparam logic [CNT_W-1:0] WR_BUSY_RST = 5'd20;
  localparam logic [CNT_W-1:0] ACK_TRY_RST = 5'd20;
  localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY_TMO = 2'd1;
  localparam logic [1:0] ST_ACK_TMO  = 2'd2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_RX    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_RDATA = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // One decoded input item.
  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        page;
    logic [7:0]        offset;
    logic [LEN_W-1:0]  length;
    logic [BUF_AW-1:0] byte_index;
    logic [7:0]        data;
  } item_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Up to two results written into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } out_push_t;

  // Configuration write.
  typedef struct packed {
    logic             valid;
    logic [1:0]       index;
    logic [CNT_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: src/srs_front.sv
// Front end: accepts input items, drops zero-length reads, saturates length, queues items.
module srs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_cmd,
  input  logic [7:0]                 in_page,
  input  logic [7:0]                 in_offset,
  input  logic [srs_pkg::LEN_W-1:0]  in_length,
  input  logic [srs_pkg::BUF_AW-1:0] in_byte_index,
  input  logic [7:0]                 in_data,
  output logic                       q_valid,
  output srs_pkg::item_t             q_item,
  input  logic                       q_pop
);

  localparam int PW = $clog2(srs_pkg::INQ_DEPTH);
  localparam int CW = $clog2(srs_pkg::INQ_DEPTH + 1);

  srs_pkg::item_t  slot_r [srs_pkg::INQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  srs_pkg::item_t  dec;
  logic            keep;
  logic            push;

  // Classify the incoming item; a zero-length read has no effect at all.
  always_comb begin
    dec.cmd        = srs_pkg::cmd_t'(in_cmd);
    dec.page       = in_page;
    dec.offset     = in_offset;
    dec.length     = (in_length > srs_pkg::LEN_W'(srs_pkg::MAX_BYTES)) ?
                     srs_pkg::LEN_W'(srs_pkg::MAX_BYTES) : in_length;
    dec.byte_index = in_byte_index;
    dec.data       = in_data;
  end

  assign keep    = !((dec.cmd == srs_pkg::CMD_READ) && (in_length == '0));
  assign in_full = (cnt_r == CW'(srs_pkg::INQ_DEPTH));
  assign push    = in_push && !in_full && keep;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: src/srs_back.sv
// Back end: the paged access sequencer, its write buffer and configuration registers.
module srs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  srs_pkg::cfg_wr_t   cfg,
  input  logic               q_valid,
  input  srs_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic               out_room,
  output srs_pkg::out_push_t push
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_POLL, PH_PAGE, PH_OFFS, PH_ACK, PH_RDATA, PH_WDATA
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [3:0]                   fbc_r, fbc_nxt;
  logic [srs_pkg::CNT_W-1:0]    pc_r, pc_nxt;
  logic                         is_wr_r, is_wr_nxt;
  logic [7:0]                   page_r, page_nxt;
  logic [7:0]                   offs_r, offs_nxt;
  logic [srs_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [1:0]                   err_r, err_nxt;
  logic [srs_pkg::CNT_W-1:0]    rd_lim_r, wr_lim_r, ack_lim_r;
  logic [7:0]                   buf_r [srs_pkg::MAX_BYTES];
  logic                         take;
  logic [7:0]                   d;
  logic [srs_pkg::CNT_W:0]      pc_inc;
  logic                         fail;
  logic [4:0]                   f5;
  logic [4:0]                   len5;
  logic [3:0]                   nxt_idx;

  function automatic srs_pkg::res_t tx_res(input logic [7:0] b, input logic fs,
                                           input logic fe);
    srs_pkg::res_t r;
    r             = '0;
    r.kind        = srs_pkg::KIND_TX;
    r.tx_byte     = b;
    r.frame_start = fs;
    r.frame_end   = fe;
    return r;
  endfunction

  function automatic srs_pkg::res_t done_res(input logic [1:0] st);
    srs_pkg::res_t r;
    r        = '0;
    r.kind   = srs_pkg::KIND_DONE;
    r.status = st;
    return r;
  endfunction

  function automatic srs_pkg::res_t rd_res(input logic [7:0] b, input logic lst);
    srs_pkg::res_t r;
    r           = '0;
    r.kind      = srs_pkg::KIND_RDATA;
    r.read_byte = b;
    r.last      = lst;
    return r;
  endfunction

  // An item is carried out only when the output queue has room for two results.
  assign take    = q_valid && out_room;
  assign q_pop   = take;
  assign d       = q_item.data;
  assign pc_inc  = {1'b0, pc_r} + (srs_pkg::CNT_W + 1)'(1);
  assign f5      = {1'b0, fbc_r};
  assign len5    = {1'b0, len_r};
  assign nxt_idx = fbc_r - 4'd1;

  // Busy poll failure test differs between reads and writes.
  always_comb begin
    if (is_wr_r) begin
      fail = (pc_r > wr_lim_r) || (pc_r == srs_pkg::CNT_MAX);
    end else begin
      fail = !(pc_inc < {1'b0, rd_lim_r});
    end
  end

  // Sequencer next state and results.
  always_comb begin
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    pc_nxt    = pc_r;
    is_wr_nxt = is_wr_r;
    page_nxt  = page_r;
    offs_nxt  = offs_r;
    len_nxt   = len_r;
    err_nxt   = err_r;
    push      = '0;
    if (take && (phase_r == PH_IDLE)) begin
      if ((q_item.cmd == srs_pkg::CMD_READ) || (q_item.cmd == srs_pkg::CMD_WRITE)) begin
        page_nxt  = q_item.page;
        offs_nxt  = q_item.offset;
        len_nxt   = q_item.length;
        is_wr_nxt = (q_item.cmd == srs_pkg::CMD_WRITE);
        pc_nxt    = '0;
        err_nxt   = '0;
        phase_nxt = PH_POLL;
        fbc_nxt   = '0;
        push.n    = 2'd1;
        push.r0   = tx_res(srs_pkg::SPI_OP_READ, 1'b1, 1'b0);
      end
    end else if (take && (q_item.cmd == srs_pkg::CMD_RX)) begin
      push.n = 2'd1;
      unique case (phase_r)
        PH_POLL: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(srs_pkg::SPI_REG_STATUS, 1'b0, 1'b0);
          end else if (fbc_r == 4'd1) begin
            fbc_nxt = 4'd2;
            push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b1);
          end else if (d[srs_pkg::SPIF_BIT] && !fail) begin
            pc_nxt  = pc_inc[srs_pkg::CNT_W-1:0];
            fbc_nxt = '0;
            push.r0 = tx_res(srs_pkg::SPI_OP_READ, 1'b1, 1'b0);
          end else begin
            if (d[srs_pkg::SPIF_BIT]) begin
              err_nxt = srs_pkg::ST_BUSY_TMO;
            end
            phase_nxt = PH_PAGE;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_WRITE, 1'b1, 1'b0);
          end
        end
        PH_PAGE: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(srs_pkg::SPI_REG_PAGE, 1'b0, 1'b0);
          end else if (fbc_r == 4'd1) begin
            fbc_nxt = 4'd2;
            push.r0 = tx_res(page_r, 1'b0, 1'b1);
          end else if (err_r != srs_pkg::ST_OK) begin
            phase_nxt = PH_IDLE;
            fbc_nxt   = '0;
            push.r0   = done_res(err_r);
          end else if (is_wr_r) begin
            phase_nxt = PH_WDATA;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_WRITE, 1'b1, 1'b0);
          end else begin
            phase_nxt = PH_OFFS;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_READ, 1'b1, 1'b0);
          end
        end
        PH_OFFS: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(offs_r, 1'b0, 1'b0);
          end else if (fbc_r == 4'd1) begin
            fbc_nxt = 4'd2;
            push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b1);
          end else begin
            pc_nxt    = '0;
            phase_nxt = PH_ACK;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_READ, 1'b1, 1'b0);
          end
        end
        PH_ACK: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(srs_pkg::SPI_REG_STATUS, 1'b0, 1'b0);
          end else if (fbc_r == 4'd1) begin
            fbc_nxt = 4'd2;
            push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b0);
          end else if (fbc_r == 4'd2) begin
            if (d[srs_pkg::RACK_BIT]) begin
              err_nxt = srs_pkg::ST_OK;
              fbc_nxt = 4'd3;
              push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b1);
            end else if (pc_inc < {1'b0, ack_lim_r}) begin
              pc_nxt  = pc_inc[srs_pkg::CNT_W-1:0];
              push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b0);
            end else begin
              err_nxt = srs_pkg::ST_ACK_TMO;
              fbc_nxt = 4'd3;
              push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, 1'b1);
            end
          end else if (err_r != srs_pkg::ST_OK) begin
            phase_nxt = PH_PAGE;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_WRITE, 1'b1, 1'b0);
          end else begin
            phase_nxt = PH_RDATA;
            fbc_nxt   = '0;
            push.r0   = tx_res(srs_pkg::SPI_OP_READ, 1'b1, 1'b0);
          end
        end
        PH_RDATA: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(srs_pkg::SPI_REG_DATA, 1'b0, 1'b0);
          end else if (fbc_r == 4'd1) begin
            fbc_nxt = 4'd2;
            push.r0 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, (len_r <= 4'd1));
          end else begin
            // Every data byte is reported, then either done or the next clocking byte.
            push.n = 2'd2;
            if (f5 >= len5 + 5'd1) begin
              push.r0   = rd_res(d, 1'b1);
              push.r1   = done_res(srs_pkg::ST_OK);
              phase_nxt = PH_IDLE;
              fbc_nxt   = '0;
            end else begin
              push.r0 = rd_res(d, 1'b0);
              push.r1 = tx_res(srs_pkg::SPI_DUMMY, 1'b0, (f5 == len5));
              fbc_nxt = fbc_r + 4'd1;
            end
          end
        end
        PH_WDATA: begin
          if (fbc_r == 4'd0) begin
            fbc_nxt = 4'd1;
            push.r0 = tx_res(offs_r, 1'b0, (len_r == '0));
          end else if ((f5 >= len5 + 5'd1) || (f5 > 5'(srs_pkg::MAX_BYTES))) begin
            phase_nxt = PH_IDLE;
            fbc_nxt   = '0;
            push.r0   = done_res(srs_pkg::ST_OK);
          end else begin
            fbc_nxt = fbc_r + 4'd1;
            push.r0 = tx_res(buf_r[nxt_idx[srs_pkg::BUF_AW-1:0]], 1'b0, (f5 == len5));
          end
        end
        default: begin
          push.n = 2'd0;
        end
      endcase
    end
  end

  // Sequencer state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      fbc_r     <= '0;
      pc_r      <= '0;
      is_wr_r   <= 1'b0;
      page_r    <= '0;
      offs_r    <= '0;
      len_r     <= '0;
      err_r     <= '0;
      rd_lim_r  <= srs_pkg::RD_BUSY_RST;
      wr_lim_r  <= srs_pkg::WR_BUSY_RST;
      ack_lim_r <= srs_pkg::ACK_TRY_RST;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      pc_r    <= pc_nxt;
      is_wr_r <= is_wr_nxt;
      page_r  <= page_nxt;
      offs_r  <= offs_nxt;
      len_r   <= len_nxt;
      err_r   <= err_nxt;
      if (cfg.valid) begin
        case (cfg.index)
          srs_pkg::CFG_RD_BUSY_LIM: rd_lim_r  <= cfg.data;
          srs_pkg::CFG_WR_BUSY_LIM: wr_lim_r  <= cfg.data;
          srs_pkg::CFG_ACK_TRIES:   ack_lim_r <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // Write data buffer, loaded only while idle.
  always_ff @(posedge clk) begin
    if (take && (phase_r == PH_IDLE) && (q_item.cmd == srs_pkg::CMD_LOAD)) begin
      buf_r[q_item.byte_index] <= q_item.data;
    end
  end

  // Idle always leaves the frame byte count cleared.
  a_idle_fbc: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (fbc_r == '0))
    else $error("frame byte count not cleared in idle");

  // Two results come only from a read data byte.
  a_two_res: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (phase_r == PH_RDATA))
    else $error("two results outside read data phase");

  // Results are only produced for an item that was taken.
  a_res_take: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> take)
    else $error("result without a taken item");

  // In idle only a start command produces anything.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (phase_r == PH_IDLE) && (q_item.cmd != srs_pkg::CMD_READ) &&
     (q_item.cmd != srs_pkg::CMD_WRITE)) |-> (push.n == 2'd0))
    else $error("result from a non-start item in idle");

endmodule

FILE: src/srs_outq.sv
// Result queue: takes up to two results a cycle, hands out one at a time.
module srs_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  srs_pkg::out_push_t push,
  output logic               room,
  output logic               empty,
  output srs_pkg::res_t      head,
  input  logic               pop
);

  localparam int PW = $clog2(srs_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(srs_pkg::OUTQ_DEPTH + 1);

  srs_pkg::res_t slot_r [srs_pkg::OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          deq;

  assign empty = (cnt_r == '0);
  assign room  = (cnt_r <= CW'(srs_pkg::OUTQ_DEPTH - 2));
  assign head  = slot_r[rd_ptr_r];
  assign deq   = pop && !empty;

  // Pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.n);
    rd_ptr_nxt = deq ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.n) - CW'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage: the first result at the write pointer, the second just after it.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slot_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slot_r[wr_ptr_r + PW'(1)] <= push.r1;
    end
  end

endmodule

FILE: src/spi_switch_register_access_sequencer_unit.sv
// Top level of the SPI switch register access sequencer.
//
//  channel | direction | handshake         | payload
//  in_     | in        | in_push / in_full | cmd, page, offset, length, byte_index, data
//  out_    | out       | out_pop / out_empty | kind, tx_byte, frame_start, frame_end,
//          |           |                   | read_byte, status, last
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle is taken while the input queue is not full; an accepted item goes
// through a two-entry input queue to the sequencer, whose results are registered in a queue.
// The sequencer carries out one item per cycle while the four-entry result queue has
// room for two results; a read data byte yields two results, every other item at most one.
// Reset (synchronous, rst_n low) empties both queues and returns to idle with the default
// poll limits; the write buffer is not cleared. cfg_ready is always high.
module spi_switch_register_access_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_cmd,
  input  logic [7:0]                 in_page,
  input  logic [7:0]                 in_offset,
  input  logic [srs_pkg::LEN_W-1:0]  in_length,
  input  logic [srs_pkg::BUF_AW-1:0] in_byte_index,
  input  logic [7:0]                 in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_tx_byte,
  output logic                       out_frame_start,
  output logic                       out_frame_end,
  output logic [7:0]                 out_read_byte,
  output logic [1:0]                 out_status,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [srs_pkg::CNT_W-1:0]  cfg_data
);

  srs_pkg::item_t     q_item;
  logic               q_valid;
  logic               q_pop;
  srs_pkg::out_push_t push;
  logic               out_room;
  srs_pkg::res_t      head;
  srs_pkg::cfg_wr_t   cfg;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  srs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_page       (in_page),
    .in_offset     (in_offset),
    .in_length     (in_length),
    .in_byte_index (in_byte_index),
    .in_data       (in_data),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  srs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_room (out_room),
    .push     (push)
  );

  srs_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (out_room),
    .empty (out_empty),
    .head  (head),
    .pop   (out_pop)
  );

  // Result fields.
  assign out_kind        = head.kind;
  assign out_tx_byte     = head.tx_byte;
  assign out_frame_start = head.frame_start;
  assign out_frame_end   = head.frame_end;
  assign out_read_byte   = head.read_byte;
  assign out_status      = head.status;
  assign out_last        = head.last;

endmodule

FILE: verif/switch_access_tracker_pkg.sv
`timescale 1ns / 100ps
// Expected-result tracker for the SPI switch register access sequencer testbench.
package switch_access_tracker_pkg;
  import srs_pkg::*;

  // Progress of one paged access, as the tracker follows it.
  typedef enum int {
    SQ_IDLE,
    SQ_POLL,
    SQ_PAGE,
    SQ_OFFS,
    SQ_ACK,
    SQ_RDATA,
    SQ_WDATA
  } seq_phase_t;

  class switch_access_tracker;
    // Poll limits as last written to the block.
    logic [CNT_W-1:0] rd_busy_lim;
    logic [CNT_W-1:0] wr_busy_lim;
    logic [CNT_W-1:0] ack_tries;

    // Access in progress.
    seq_phase_t       phase;
    int unsigned      frame_pos;
    int unsigned      polls;
    int unsigned      op_len;
    bit               op_write;
    logic [7:0]       op_page;
    logic [7:0]       op_offset;
    logic [1:0]       err_status;
    logic [7:0]       wbuf [MAX_BYTES];

    // Results the block still owes, oldest first.
    res_t             awaited_q [$];
    int unsigned      mismatches;

    function new();
      rd_busy_lim = RD_BUSY_RST;
      wr_busy_lim = WR_BUSY_RST;
      ack_tries   = ACK_TRY_RST;
      phase       = SQ_IDLE;
      frame_pos   = 0;
      polls       = 0;
      op_len      = 0;
      op_write    = 1'b0;
      op_page     = '0;
      op_offset   = '0;
      err_status  = ST_OK;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        CFG_RD_BUSY_LIM: rd_busy_lim = val;
        CFG_WR_BUSY_LIM: wr_busy_lim = val;
        CFG_ACK_TRIES:   ack_tries   = val;
        default: ;
      endcase
    endfunction

    function void add_tx(logic [7:0] b, bit fs, bit fe);
      res_t r;
      r = '0;
      r.kind        = KIND_TX;
      r.tx_byte     = b;
      r.frame_start = fs;
      r.frame_end   = fe;
      awaited_q.push_back(r);
    endfunction

    function void add_read_byte(logic [7:0] d, bit last);
      res_t r;
      r = '0;
      r.kind      = KIND_RDATA;
      r.read_byte = d;
      r.last      = last;
      awaited_q.push_back(r);
    endfunction

    function void add_done(logic [1:0] st);
      res_t r;
      r = '0;
      r.kind   = KIND_DONE;
      r.status = st;
      awaited_q.push_back(r);
      phase     = SQ_IDLE;
      frame_pos = 0;
    endfunction

    function void open_frame(seq_phase_t ph, logic [7:0] op);
      phase     = ph;
      frame_pos = 0;
      add_tx(op, 1'b1, 1'b0);
    endfunction

    // A byte has come back from SPI: it decides what is sent next.
    function void rx_byte(logic [7:0] d);
      int unsigned f;
      int unsigned i;
      bit          fail;
      f = frame_pos;
      case (phase)
        SQ_POLL: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(SPI_REG_STATUS, 1'b0, 1'b0);
          end else if (f == 1) begin
            frame_pos = 2;
            add_tx(SPI_DUMMY, 1'b0, 1'b1);
          end else if (d[SPIF_BIT]) begin
            // Still busy: either give up or poll again.
            if (op_write) fail = (polls > wr_busy_lim) || (polls >= CNT_MAX);
            else          fail = !(polls + 1 < rd_busy_lim);
            if (fail) begin
              err_status = ST_BUSY_TMO;
              open_frame(SQ_PAGE, SPI_OP_WRITE);
            end else begin
              polls++;
              open_frame(SQ_POLL, SPI_OP_READ);
            end
          end else begin
            open_frame(SQ_PAGE, SPI_OP_WRITE);
          end
        end
        SQ_PAGE: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(SPI_REG_PAGE, 1'b0, 1'b0);
          end else if (f == 1) begin
            frame_pos = 2;
            add_tx(op_page, 1'b0, 1'b1);
          end else if (err_status != ST_OK) begin
            add_done(err_status);
          end else if (op_write) begin
            open_frame(SQ_WDATA, SPI_OP_WRITE);
          end else begin
            open_frame(SQ_OFFS, SPI_OP_READ);
          end
        end
        SQ_OFFS: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(op_offset, 1'b0, 1'b0);
          end else if (f == 1) begin
            frame_pos = 2;
            add_tx(SPI_DUMMY, 1'b0, 1'b1);
          end else begin
            polls = 0;
            open_frame(SQ_ACK, SPI_OP_READ);
          end
        end
        SQ_ACK: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(SPI_REG_STATUS, 1'b0, 1'b0);
          end else if (f == 1) begin
            frame_pos = 2;
            add_tx(SPI_DUMMY, 1'b0, 1'b0);
          end else if (f == 2) begin
            // Keep clocking status bytes until the acknowledge shows up or the tries run out.
            if (d[RACK_BIT]) begin
              err_status = ST_OK;
              frame_pos  = 3;
              add_tx(SPI_DUMMY, 1'b0, 1'b1);
            end else if (polls + 1 < ack_tries) begin
              polls++;
              add_tx(SPI_DUMMY, 1'b0, 1'b0);
            end else begin
              err_status = ST_ACK_TMO;
              frame_pos  = 3;
              add_tx(SPI_DUMMY, 1'b0, 1'b1);
            end
          end else if (err_status != ST_OK) begin
            open_frame(SQ_PAGE, SPI_OP_WRITE);
          end else begin
            open_frame(SQ_RDATA, SPI_OP_READ);
          end
        end
        SQ_RDATA: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(SPI_REG_DATA, 1'b0, 1'b0);
          end else if (f == 1) begin
            frame_pos = 2;
            add_tx(SPI_DUMMY, 1'b0, op_len <= 1);
          end else begin
            i = f - 2;
            add_read_byte(d, i + 1 >= op_len);
            if (i + 1 >= op_len) begin
              add_done(ST_OK);
            end else begin
              frame_pos = f + 1;
              add_tx(SPI_DUMMY, 1'b0, i + 2 == op_len);
            end
          end
        end
        SQ_WDATA: begin
          if (f == 0) begin
            frame_pos = 1;
            add_tx(op_offset, 1'b0, op_len == 0);
          end else begin
            i = f - 1;
            if (i >= op_len || i >= MAX_BYTES) begin
              add_done(ST_OK);
            end else begin
              frame_pos = f + 1;
              add_tx(wbuf[i[BUF_AW-1:0]], 1'b0, i + 1 == op_len);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Notes an accepted input item; returns 1 when the block acts on it.
    function bit note_request(item_t it);
      int unsigned len;
      if (it.cmd == CMD_RX) begin
        if (phase == SQ_IDLE) return 1'b0;
        rx_byte(it.data);
        return 1'b1;
      end
      if (phase != SQ_IDLE) return 1'b0;
      if (it.cmd == CMD_LOAD) begin
        wbuf[it.byte_index] = it.data;
        return 1'b1;
      end
      if (it.cmd == CMD_READ && it.length == 0) return 1'b0;
      len        = (it.length > MAX_BYTES) ? MAX_BYTES : it.length;
      op_page    = it.page;
      op_offset  = it.offset;
      op_len     = len;
      op_write   = (it.cmd == CMD_WRITE);
      polls      = 0;
      err_status = ST_OK;
      open_frame(SQ_POLL, SPI_OP_READ);
      return 1'b1;
    endfunction

    function void note_mismatch(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: want kind %0d tx %02h fs %0d fe %0d rd %02h st %0d last %0d",
                 $time, what, want.kind, want.tx_byte, want.frame_start, want.frame_end,
                 want.read_byte, want.status, want.last);
      if (mismatches <= 10)
        $display("%0t %s: got  kind %0d tx %02h fs %0d fe %0d rd %02h st %0d last %0d",
                 $time, what, got.kind, got.tx_byte, got.frame_start, got.frame_end,
                 got.read_byte, got.status, got.last);
    endfunction

    // Compares an accepted result with the oldest one awaited.
    function void match_response(res_t got);
      res_t want;
      if (awaited_q.size() == 0) begin
        note_mismatch("result with nothing awaited", '0, got);
        return;
      end
      want = awaited_q.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
          got.frame_start !== want.frame_start || got.frame_end !== want.frame_end ||
          got.read_byte !== want.read_byte || got.status !== want.status ||
          got.last !== want.last)
        note_mismatch("result differs", want, got);
    endfunction
  endclass

endpackage

FILE: verif/spi_switch_register_access_sequencer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench top for the SPI switch register access sequencer.
module spi_switch_register_access_sequencer_unit_test;
  import srs_pkg::*;
  import switch_access_tracker_pkg::*;

  localparam int ITEM_TARGET   = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  // How the simulated switch answers status polls during one access.
  typedef enum int {
    REPLY_NORMAL,
    REPLY_STUCK_BUSY,
    REPLY_NO_ACK
  } reply_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [1:0]           in_cmd;
  logic [7:0]           in_page;
  logic [7:0]           in_offset;
  logic [LEN_W-1:0]     in_length;
  logic [BUF_AW-1:0]    in_byte_index;
  logic [7:0]           in_data;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_tx_byte;
  logic                 out_frame_start;
  logic                 out_frame_end;
  logic [7:0]           out_read_byte;
  logic [1:0]           out_status;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  switch_access_tracker tracker;
  int                   send_calm;
  int                   pop_hold = 0;
  int                   pop_calm = 0;
  int                   stall_cycles = 0;
  int                   n_items;

  spi_switch_register_access_sequencer_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_page         (in_page),
    .in_offset       (in_offset),
    .in_length       (in_length),
    .in_byte_index   (in_byte_index),
    .in_data         (in_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_read_byte   (out_read_byte),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: pop stalls of random length, mostly short, with calm stretches.
  always @(posedge clk) begin : pop_pacing
    int r;
    r = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (pop_calm > 0) pop_calm--;
      else if (r < 15) pop_hold = $urandom_range(1, 3);
      else if (r < 18) pop_hold = $urandom_range(10, 40);
      else if (r < 20) pop_calm = $urandom_range(50, 200);
    end
  end

  // Check every accepted result and stop the run if the block goes quiet.
  always @(posedge clk) begin : result_watch
    res_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.kind        = kind_t'(out_kind);
      got.tx_byte     = out_tx_byte;
      got.frame_start = out_frame_start;
      got.frame_end   = out_frame_end;
      got.read_byte   = out_read_byte;
      got.status      = out_status;
      got.last        = out_last;
      tracker.match_response(got);
    end
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.cmd        = cmd_t'($urandom_range(0, 3));
    it.page       = 8'($urandom_range(0, 255));
    it.offset     = 8'($urandom_range(0, 255));
    it.length     = LEN_W'($urandom_range(0, 15));
    it.byte_index = BUF_AW'($urandom_range(0, 7));
    it.data       = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Byte the switch sends back; status replies are steered by the reply mode.
  function automatic logic [7:0] reply_byte(reply_mode_t mode);
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    if (tracker.phase == SQ_POLL && tracker.frame_pos == 2)
      d[SPIF_BIT] = (mode == REPLY_STUCK_BUSY) ? 1'b1 : ($urandom_range(0, 99) < 20);
    else if (tracker.phase == SQ_ACK && tracker.frame_pos == 2)
      d[RACK_BIT] = (mode == REPLY_NO_ACK) ? 1'b0 : ($urandom_range(0, 99) < 40);
    return d;
  endfunction

  // Sender gap after an item: mostly none or short, a few long, with calm stretches.
  task automatic sender_gap();
    int n;
    int r;
    n = 0;
    r = $urandom_range(0, 99);
    if (send_calm > 0) send_calm--;
    else if (r < 25) n = $urandom_range(1, 3);
    else if (r < 29) n = $urandom_range(10, 40);
    else if (r < 31) send_calm = $urandom_range(30, 120);
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic push_item(item_t it);
    in_push       <= 1'b1;
    in_cmd        <= it.cmd;
    in_page       <= it.page;
    in_offset     <= it.offset;
    in_length     <= it.length;
    in_byte_index <= it.byte_index;
    in_data       <= it.data;
    do @(posedge clk); while (in_full);
    if (tracker.note_request(it)) n_items++;
    sender_gap();
  endtask

  // Hold off the sender until every awaited result has been taken.
  task automatic pause_for_results();
    in_push <= 1'b0;
    do @(posedge clk); while (tracker.awaited_q.size() != 0);
  endtask

  task automatic push_reply(reply_mode_t mode);
    item_t it;
    it      = random_item();
    it.cmd  = CMD_RX;
    it.data = reply_byte(mode);
    push_item(it);
  endtask

  // Feed SPI replies until the access completes, with ignored commands mixed in.
  task automatic finish_access(reply_mode_t mode);
    item_t it;
    int    r;
    while (tracker.phase != SQ_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        pause_for_results();
      end else if (r < 8) begin
        it     = random_item();
        it.cmd = cmd_t'($urandom_range(0, 2));
        push_item(it);
      end
      push_reply(mode);
    end
  endtask

  // Write all three poll limits while the block is idle.
  task automatic apply_limits(input logic [CNT_W-1:0] rd, wr, ack);
    logic [1:0]       idx [3];
    logic [CNT_W-1:0] val [3];
    idx = '{CFG_RD_BUSY_LIM, CFG_WR_BUSY_LIM, CFG_ACK_TRIES};
    val = '{rd, wr, ack};
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_register(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    item_t            it;
    reply_mode_t      mode;
    cmd_t             op;
    logic [LEN_W-1:0] len;
    logic [7:0]       fill_bytes [MAX_BYTES];
    int               op_count;
    int               r;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_cmd        = '0;
    in_page       = '0;
    in_offset     = '0;
    in_length     = '0;
    in_byte_index = '0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_calm     = 0;
    n_items       = 0;
    op_count      = 0;
    fill_bytes    = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
    tracker       = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole write buffer first so no write ever sends an unloaded byte.
    for (int i = 0; i < MAX_BYTES; i++) begin
      it            = random_item();
      it.cmd        = CMD_LOAD;
      it.byte_index = BUF_AW'(i);
      it.data       = fill_bytes[i];
      push_item(it);
    end

    // A received byte while idle and a zero-length read are both ignored.
    it      = random_item();
    it.cmd  = CMD_RX;
    it.data = 8'hFF;
    push_item(it);
    it        = random_item();
    it.cmd    = CMD_READ;
    it.length = '0;
    push_item(it);

    // Zero-length write at the extreme page and offset, with a start and a load
    // offered while it is busy.
    it        = random_item();
    it.cmd    = CMD_WRITE;
    it.page   = 8'hFF;
    it.offset = 8'h00;
    it.length = '0;
    push_item(it);
    push_reply(REPLY_NORMAL);
    it        = random_item();
    it.cmd    = CMD_READ;
    it.length = '1;
    push_item(it);
    it      = random_item();
    it.cmd  = CMD_LOAD;
    push_item(it);
    finish_access(REPLY_NORMAL);

    // Random accesses, the poll limits changing every ten of them.
    while (n_items < ITEM_TARGET) begin
      if (op_count % 10 == 0) begin
        case ((op_count / 10) % 6)
          0:       apply_limits(5'd1, 5'd0, 5'd1);
          1:       apply_limits(CNT_MAX, CNT_MAX, CNT_MAX);
          2:       apply_limits(5'd0, CNT_MAX, 5'd0);
          3:       apply_limits(RD_BUSY_RST, WR_BUSY_RST, ACK_TRY_RST);
          default: apply_limits(CNT_W'($urandom_range(0, 31)), CNT_W'($urandom_range(0, 31)),
                                CNT_W'($urandom_range(0, 31)));
        endcase
      end

      // Some idle-time traffic: buffer loads, stray bytes, zero-length reads.
      repeat ($urandom_range(0, 2)) begin
        it = random_item();
        r  = $urandom_range(0, 3);
        if (r < 2) it.cmd = CMD_LOAD;
        else if (r == 2) it.cmd = CMD_RX;
        else begin
          it.cmd    = CMD_READ;
          it.length = '0;
        end
        push_item(it);
      end

      op = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      r  = $urandom_range(0, 99);
      if (r < 10) len = LEN_W'($urandom_range(9, 15));
      else if (r < 18 && op == CMD_WRITE) len = '0;
      else len = LEN_W'($urandom_range(1, 8));
      r = $urandom_range(0, 99);
      if (r < 70) mode = REPLY_NORMAL;
      else if (r < 85) mode = REPLY_STUCK_BUSY;
      else mode = REPLY_NO_ACK;

      it        = random_item();
      it.cmd    = op;
      it.length = len;
      push_item(it);
      finish_access(mode);
      op_count++;
    end

    // Drain, let the block settle, then report.
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
